// ===== sv/pip_pkg.sv =====
// Shared constant for the point-in-polygon crossing test.
// No dependencies.
package pip_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

endpackage

// ===== sv/point_in_polygon_crossing_test.sv =====
// A result word is shown once the word carrying the last vertex has passed the input,
// product and result registers. Throughput: one vertex word per cycle while stall_o is
// low; stage 1 forms the cross products, stage 2 compares them and folds the parity.
// Reset (rst_ni low, asynchronous): pipeline empty, stored vertices (0, 0), parity clear.
// Depends on pip_pkg, pip_edge_prep, pip_box.
module point_in_polygon_crossing_test #(
  parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] query_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic        [COORD_WIDTH-2:0] box_radius_i,
  input  logic                          first_vertex_i,
  input  logic                          last_vertex_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic                          inside_res_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  // input stage
  logic                  a_valid_q;
  logic signed [W-1:0]   a_qx_q, a_qy_q, a_vx_q, a_vy_q, a_cx_q, a_cy_q;
  logic        [W-2:0]   a_r_q;
  logic                  a_first_q, a_last_q;

  // polygon state
  logic signed [W-1:0]   prev_vx_q, prev_vy_q, start_vx_q, start_vy_q;
  logic signed [W-1:0]   start_vx_eff, start_vy_eff;

  // product stage
  logic                  b_valid_q;
  logic                  b_first_q, b_last_q, b_box_q;
  logic                  b_span0_q, b_rise0_q, b_span1_q, b_rise1_q;
  logic signed [PW-1:0]  b_pl0_q, b_pr0_q, b_pl1_q, b_pr1_q;

  logic                  span0, rise0, span1, rise1, in_box;
  logic signed [PW-1:0]  pl0, pr0, pl1, pr1;

  logic                  parity_q;
  logic                  out_valid_q, out_res_q;

  logic                  o_free, b_go, b_free, a_go, a_free, accept;
  logic signed [PW:0]    diff0, diff1;
  logic                  cross0, cross1, parity_d;

  assign o_free  = !out_valid_q || !stall_i;
  assign b_go    = b_valid_q && (!b_last_q || o_free);
  assign b_free  = !b_valid_q || b_go;
  assign a_go    = a_valid_q && b_free;
  assign a_free  = !a_valid_q || b_free;
  assign stall_o = !a_free;
  assign accept  = valid_i && a_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_free) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_qx_q    <= query_x_i;
      a_qy_q    <= query_y_i;
      a_vx_q    <= vertex_x_i;
      a_vy_q    <= vertex_y_i;
      a_cx_q    <= center_x_i;
      a_cy_q    <= center_y_i;
      a_r_q     <= box_radius_i;
      a_first_q <= first_vertex_i;
      a_last_q  <= last_vertex_i;
    end
  end

  assign start_vx_eff = a_first_q ? a_vx_q : start_vx_q;
  assign start_vy_eff = a_first_q ? a_vy_q : start_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vx_q  <= '0;
      prev_vy_q  <= '0;
      start_vx_q <= '0;
      start_vy_q <= '0;
    end else if (a_go) begin
      prev_vx_q  <= a_vx_q;
      prev_vy_q  <= a_vy_q;
      start_vx_q <= start_vx_eff;
      start_vy_q <= start_vy_eff;
    end
  end

  // edge from the current vertex back to the previous one
  pip_edge_prep #(.COORD_WIDTH(COORD_WIDTH)) u_edge_prev (
    .en_i     (!a_first_q),
    .x1_i     (a_vx_q),
    .y1_i     (a_vy_q),
    .x2_i     (prev_vx_q),
    .y2_i     (prev_vy_q),
    .qx_i     (a_qx_q),
    .qy_i     (a_qy_q),
    .span_o   (span0),
    .rising_o (rise0),
    .prod_l_o (pl0),
    .prod_r_o (pr0)
  );

  // closing edge from the first vertex to the current one
  pip_edge_prep #(.COORD_WIDTH(COORD_WIDTH)) u_edge_close (
    .en_i     (a_last_q),
    .x1_i     (start_vx_eff),
    .y1_i     (start_vy_eff),
    .x2_i     (a_vx_q),
    .y2_i     (a_vy_q),
    .qx_i     (a_qx_q),
    .qy_i     (a_qy_q),
    .span_o   (span1),
    .rising_o (rise1),
    .prod_l_o (pl1),
    .prod_r_o (pr1)
  );

  pip_box #(.COORD_WIDTH(COORD_WIDTH)) u_box (
    .qx_i     (a_qx_q),
    .qy_i     (a_qy_q),
    .cx_i     (a_cx_q),
    .cy_i     (a_cy_q),
    .r_i      (a_r_q),
    .in_box_o (in_box)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_first_q <= a_first_q;
      b_last_q  <= a_last_q;
      b_box_q   <= in_box;
      b_span0_q <= span0;
      b_rise0_q <= rise0;
      b_pl0_q   <= pl0;
      b_pr0_q   <= pr0;
      b_span1_q <= span1;
      b_rise1_q <= rise1;
      b_pl1_q   <= pl1;
      b_pr1_q   <= pr1;
    end
  end

  assign diff0  = (PW + 1)'(b_pl0_q) - (PW + 1)'(b_pr0_q);
  assign diff1  = (PW + 1)'(b_pl1_q) - (PW + 1)'(b_pr1_q);
  assign cross0 = b_span0_q && (b_rise0_q ? (!diff0[PW] && (diff0 != '0)) : diff0[PW]);
  assign cross1 = b_span1_q && (b_rise1_q ? (!diff1[PW] && (diff1 != '0)) : diff1[PW]);

  assign parity_d = ((b_first_q ? 1'b0 : parity_q) ^ cross0) ^ (b_last_q & cross1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else if (b_go) begin
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_go && b_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && b_last_q) begin
      out_res_q <= parity_d & b_box_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign inside_res_o = out_res_q;

endmodule

// ===== sv/pip_edge_prep.sv =====
// First half of one edge test: half-open span of the query y and the two cross products.
// Depends on pip_pkg.
module pip_edge_prep #(
  parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                              en_i,
  input  logic signed [COORD_WIDTH-1:0]     x1_i,
  input  logic signed [COORD_WIDTH-1:0]     y1_i,
  input  logic signed [COORD_WIDTH-1:0]     x2_i,
  input  logic signed [COORD_WIDTH-1:0]     y2_i,
  input  logic signed [COORD_WIDTH-1:0]     qx_i,
  input  logic signed [COORD_WIDTH-1:0]     qy_i,
  output logic                              span_o,
  output logic                              rising_o,
  output logic signed [2*COORD_WIDTH+1:0]   prod_l_o,
  output logic signed [2*COORD_WIDTH+1:0]   prod_r_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] dqx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dqy;

  assign dqx = DW'(qx_i) - DW'(x1_i);
  assign dy  = DW'(y2_i) - DW'(y1_i);
  assign dx  = DW'(x2_i) - DW'(x1_i);
  assign dqy = DW'(qy_i) - DW'(y1_i);

  assign span_o   = en_i && (((y1_i <= qy_i) && (qy_i < y2_i)) ||
                             ((y2_i <= qy_i) && (qy_i < y1_i)));
  assign rising_o = (y2_i > y1_i);
  assign prod_l_o = PW'(dqx) * PW'(dy);
  assign prod_r_o = PW'(dx) * PW'(dqy);

endmodule

// ===== sv/pip_box.sv =====
// Inclusive square box test of the query point around the polygon centre.
// Depends on pip_pkg.
module pip_box #(
  parameter int unsigned COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] qx_i,
  input  logic signed [COORD_WIDTH-1:0] qy_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic        [COORD_WIDTH-2:0] r_i,
  output logic                          in_box_o
);

  localparam int unsigned EW = COORD_WIDTH + 1;

  logic signed [EW-1:0] r_ext;
  logic signed [EW-1:0] qx_ext;
  logic signed [EW-1:0] qy_ext;
  logic signed [EW-1:0] cx_ext;
  logic signed [EW-1:0] cy_ext;

  assign r_ext  = $signed({2'b00, r_i});
  assign qx_ext = EW'(qx_i);
  assign qy_ext = EW'(qy_i);
  assign cx_ext = EW'(cx_i);
  assign cy_ext = EW'(cy_i);

  assign in_box_o = (qx_ext >= cx_ext - r_ext) && (qx_ext <= cx_ext + r_ext) &&
                    (qy_ext >= cy_ext - r_ext) && (qy_ext <= cy_ext + r_ext);

endmodule
